### hw/rtl/rssi_similarity_sybil_detector_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef RSSI_SIMILARITY_SYBIL_DETECTOR_ASSERT_SVH
`define RSSI_SIMILARITY_SYBIL_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition holds at every clock edge outside reset.
`define SSD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Antecedent at one edge implies consequent at the next.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSD_ASSERT_ALWAYS(lbl, cond, msg)
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, sizes and arithmetic constants of the RSSI similarity detector.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int WINDOW_DEPTH  = 10;

    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int MEM_DEPTH = TABLE_ENTRIES * WINDOW_DEPTH;
    localparam int ADDR_W   = $clog2(MEM_DEPTH);

    localparam int SMP_W    = 8;
    localparam int SUM_W    = SMP_W + CNT_W;
    localparam int SQ_W     = 2 * SMP_W + CNT_W;
    localparam int VAR_W    = 2 * SMP_W;
    localparam int DEV_W    = SMP_W;
    localparam int MEAN_W   = SMP_W;
    localparam int SPREAD_W = 3;
    localparam int BAND_W   = DEV_W + SPREAD_W + 1;

    // reciprocal multipliers for the two divisions by the window depth
    localparam int SUM_SHIFT   = 16;
    localparam int RECIP_SUM_W = 17;
    localparam logic [RECIP_SUM_W-1:0] RECIP_SUM =
        RECIP_SUM_W'((2**SUM_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
    localparam int SQ_SHIFT    = 23;
    localparam int RECIP_SQ_W  = 24;
    localparam logic [RECIP_SQ_W-1:0] RECIP_SQ =
        RECIP_SQ_W'((2**SQ_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
    localparam int PROD_W = SQ_W + RECIP_SQ_W;

    localparam logic [2:0] SPREAD_RESET = 3'd2;

    localparam logic [2:0] K_REG    = 3'd0;
    localparam logic [2:0] K_PUSH   = 3'd1;
    localparam logic [2:0] K_POP    = 3'd2;
    localparam logic [2:0] K_CLR    = 3'd3;
    localparam logic [2:0] K_CHECK  = 3'd4;
    localparam logic [2:0] K_CLRSUS = 3'd5;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        node_id;
        logic signed [7:0] sample;
    } t_cmd;

    typedef struct packed {
        logic              id_present;
        logic              window_full;
        logic signed [7:0] popped_sample;
        logic [3:0]        entries_used;
        logic              table_overflow;
        logic [2:0]        group_index;
        logic [7:0]        member_id;
        logic              member_valid;
        logic              last_in_group;
        logic              any_suspect;
        logic              last;
    } t_result;

    typedef struct packed {
        logic mean_go;
        logic dev_go;
    } t_stat_req;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ZERO, S_POP, S_SHIFT, S_ST_NEXT, S_SUM, S_MEAN,
        S_SQ, S_DEV, S_PAIR, S_REF, S_FIN, S_RESP
    } t_state;

    typedef enum logic [2:0] {
        SU_IDLE, SU_MEAN, SU_DIV, SU_ROOT, SU_BAND
    } t_stat_state;

    function automatic logic [ADDR_W-1:0] base_addr(input logic [IDX_W-1:0] idx);
        base_addr = ADDR_W'(idx) * ADDR_W'(WINDOW_DEPTH);
    endfunction

endpackage

### hw/rtl/rssi_similarity_sybil_detector.sv
// ----------------------------------------------------------------------------
// rssi_similarity_sybil_detector
// Neighbor table with RSSI sample windows and a similarity check that
// reports groups of IDs with near-identical mean signal strength.
// ----------------------------------------------------------------------------
// Register, push, pop, clear and flag commands return a single result beat.
// Check: stats for every full window, then each (id, id) pair of full windows
//   and each group is visited; beats stream out, one per cycle max.
// Throughput: one command at a time; busy is high from accept until the last
//   beat is loaded into the output register. The receiver cannot stall.
// Reset: synchronous active low; table empty, suspect flag clear, spread 2.
//   The sample memory needs no clearing: slots are zeroed on registration.
module rssi_similarity_sybil_detector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ssd_pkg::t_cmd        i_cmd,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_wdata,
    output logic                 o_strobe,
    output ssd_pkg::t_result     o_result
);
    `include "rssi_similarity_sybil_detector_assert.svh"

    localparam int TE = ssd_pkg::TABLE_ENTRIES;
    localparam int WD = ssd_pkg::WINDOW_DEPTH;
    localparam int IW = ssd_pkg::IDX_W;
    localparam int CW = ssd_pkg::CNT_W;
    localparam int AW = ssd_pkg::ADDR_W;

    ssd_pkg::t_state r_state, n_state;

    // command beat
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_smp, n_smp;

    // table: valid bits, ids and fill counts in flops, looked up in parallel
    logic [TE-1:0] r_valid, n_valid;
    logic [7:0]    r_eid [TE];
    logic [7:0]    n_eid [TE];
    logic [CW-1:0] r_cnt [TE];
    logic [CW-1:0] n_cnt [TE];

    // per-entry check results
    logic signed [ssd_pkg::MEAN_W-1:0] r_mean [TE];
    logic signed [ssd_pkg::MEAN_W-1:0] n_mean [TE];
    logic signed [ssd_pkg::BAND_W-1:0] r_lo [TE];
    logic signed [ssd_pkg::BAND_W-1:0] n_lo [TE];
    logic signed [ssd_pkg::BAND_W-1:0] r_hi [TE];
    logic signed [ssd_pkg::BAND_W-1:0] n_hi [TE];

    // sequencer working registers
    logic [IW-1:0] r_e, n_e;
    logic [CW-1:0] r_k, n_k;
    logic          r_rv, n_rv;
    logic signed [ssd_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [ssd_pkg::SQ_W-1:0]          r_sq, n_sq;
    logic signed [ssd_pkg::MEAN_W-1:0] r_mcur, n_mcur;
    logic [IW:0]   r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW:0]   r_nfull, n_nfull;
    logic          r_found, n_found;
    logic [2:0]    r_grp, n_grp;

    // one member held back so the final beat can carry last
    logic          r_pvld, n_pvld;
    logic [7:0]    r_pid, n_pid;
    logic [2:0]    r_pgrp, n_pgrp;
    logic          r_plig, n_plig;

    logic [7:0]    r_popped, n_popped;
    logic          r_ovf, n_ovf;
    logic [2:0]    r_spread, n_spread;
    logic          r_suspect, n_suspect;

    logic               r_ovld, n_ovld;
    ssd_pkg::t_result   r_out, n_out;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    ssd_pkg::t_stat_req stat_req;
    logic                              stat_done;
    logic signed [ssd_pkg::MEAN_W-1:0] stat_mean;
    logic signed [ssd_pkg::BAND_W-1:0] stat_lo, stat_hi;

    // lookup and status
    logic          hit, free_ok;
    logic [IW-1:0] hit_idx, free_idx;
    logic [3:0]    used;
    logic [TE-1:0] full;
    logic          st_wf;
    logic [IW-1:0] ii;
    logic          pair_hit;
    logic signed [9:0]  dif;
    logic signed [19:0] dsq;

    ssd_sample_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ssd_stat_unit u_stat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (stat_req),
        .i_sum    (r_sum),
        .i_sq     (r_sq),
        .i_mean   (r_mcur),
        .i_spread (r_spread),
        .o_done   (stat_done),
        .o_mean   (stat_mean),
        .o_lo     (stat_lo),
        .o_hi     (stat_hi)
    );

    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        free_ok = 1'b0;
        free_idx = '0;
        used = '0;
        for (int i = 0; i < TE; i++) begin
            if (!hit && r_valid[i] && r_eid[i] == r_id) begin
                hit = 1'b1;
                hit_idx = IW'(i);
            end
            if (!free_ok && !r_valid[i]) begin
                free_ok = 1'b1;
                free_idx = IW'(i);
            end
            used = used + 4'(r_valid[i]);
            full[i] = r_valid[i] && (r_cnt[i] >= CW'(WD));
        end
        st_wf = hit && (r_cnt[hit_idx] >= CW'(WD));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ssd_pkg::S_IDLE;
            r_valid   <= '0;
            for (int i = 0; i < TE; i++) begin
                r_cnt[i] <= '0;
            end
            r_spread  <= ssd_pkg::SPREAD_RESET;
            r_suspect <= 1'b0;
            r_ovld    <= 1'b0;
            r_pvld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cnt     <= n_cnt;
            r_spread  <= n_spread;
            r_suspect <= n_suspect;
            r_ovld    <= n_ovld;
            r_pvld    <= n_pvld;
        end
        r_kind   <= n_kind;
        r_id     <= n_id;
        r_smp    <= n_smp;
        r_eid    <= n_eid;
        r_mean   <= n_mean;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_e      <= n_e;
        r_k      <= n_k;
        r_rv     <= n_rv;
        r_sum    <= n_sum;
        r_sq     <= n_sq;
        r_mcur   <= n_mcur;
        r_i      <= n_i;
        r_j      <= n_j;
        r_nfull  <= n_nfull;
        r_found  <= n_found;
        r_grp    <= n_grp;
        r_pid    <= n_pid;
        r_pgrp   <= n_pgrp;
        r_plig   <= n_plig;
        r_popped <= n_popped;
        r_ovf    <= n_ovf;
        r_out    <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_kind = r_kind; n_id = r_id; n_smp = r_smp;
        n_valid = r_valid; n_eid = r_eid; n_cnt = r_cnt;
        n_mean = r_mean; n_lo = r_lo; n_hi = r_hi;
        n_e = r_e; n_k = r_k; n_rv = 1'b0;
        n_sum = r_sum; n_sq = r_sq; n_mcur = r_mcur;
        n_i = r_i; n_j = r_j; n_nfull = r_nfull; n_found = r_found; n_grp = r_grp;
        n_pvld = r_pvld; n_pid = r_pid; n_pgrp = r_pgrp; n_plig = r_plig;
        n_popped = r_popped; n_ovf = r_ovf;
        n_spread = i_cfg_we ? i_cfg_wdata : r_spread;
        n_suspect = r_suspect;
        stat_req = '0;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        ii = r_i[IW-1:0];
        dif = $signed({{2{mem_rdata[7]}}, mem_rdata}) - 10'(r_mcur);
        dsq = 20'(dif) * 20'(dif);
        pair_hit = (r_j != ii) && full[r_j] &&
                   (ssd_pkg::BAND_W'(r_mean[r_j]) > r_lo[ii]) &&
                   (ssd_pkg::BAND_W'(r_mean[r_j]) < r_hi[ii]);

        // status fields of node_id after the operation, shared by all beats
        n_ovld = 1'b0;
        n_out = '0;
        n_out.id_present     = hit;
        n_out.window_full    = st_wf;
        n_out.popped_sample  = r_popped;
        n_out.entries_used   = used;
        n_out.table_overflow = r_ovf;
        n_out.any_suspect    = 1'b1;
        n_out.member_valid   = 1'b1;
        n_out.member_id      = r_pid;
        n_out.group_index    = r_pgrp;
        n_out.last_in_group  = r_plig;

        case (r_state)
            ssd_pkg::S_IDLE: begin
                if (start) begin
                    n_kind = i_cmd.kind;
                    n_id = i_cmd.node_id;
                    n_smp = i_cmd.sample;
                    n_popped = '0;
                    n_ovf = 1'b0;
                    n_state = ssd_pkg::S_DECODE;
                end
            end
            ssd_pkg::S_DECODE: begin
                n_state = ssd_pkg::S_RESP;
                case (r_kind)
                    ssd_pkg::K_REG: begin
                        if (!hit) begin
                            if (free_ok) begin
                                n_valid[free_idx] = 1'b1;
                                n_eid[free_idx] = r_id;
                                n_cnt[free_idx] = '0;
                                n_e = free_idx;
                                n_k = '0;
                                n_state = ssd_pkg::S_ZERO;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end
                    ssd_pkg::K_PUSH: begin
                        // a full window drops the sample
                        if (hit && r_cnt[hit_idx] < CW'(WD)) begin
                            mem_we = 1'b1;
                            mem_waddr = ssd_pkg::base_addr(hit_idx) + AW'(r_cnt[hit_idx]);
                            mem_wdata = r_smp;
                            n_cnt[hit_idx] = r_cnt[hit_idx] + CW'(1);
                        end
                    end
                    ssd_pkg::K_POP: begin
                        if (hit) begin
                            n_e = hit_idx;
                            mem_raddr = ssd_pkg::base_addr(hit_idx);
                            n_state = ssd_pkg::S_POP;
                        end
                    end
                    ssd_pkg::K_CLR: begin
                        n_valid = '0;
                        for (int i = 0; i < TE; i++) begin
                            n_cnt[i] = '0;
                        end
                    end
                    ssd_pkg::K_CHECK: begin
                        n_i = '0;
                        n_nfull = '0;
                        n_state = ssd_pkg::S_ST_NEXT;
                    end
                    ssd_pkg::K_CLRSUS: n_suspect = 1'b0;
                    default: n_state = ssd_pkg::S_RESP;
                endcase
            end
            ssd_pkg::S_ZERO: begin
                mem_we = 1'b1;
                mem_waddr = ssd_pkg::base_addr(r_e) + AW'(r_k);
                mem_wdata = '0;
                n_k = r_k + CW'(1);
                if (r_k == CW'(WD - 1)) begin
                    n_state = ssd_pkg::S_RESP;
                end
            end
            ssd_pkg::S_POP: begin
                // oldest slot comes back even from an empty window
                n_popped = mem_rdata;
                n_state = ssd_pkg::S_RESP;
                if (r_cnt[r_e] > CW'(1)) begin
                    mem_raddr = ssd_pkg::base_addr(r_e) + AW'(1);
                    n_k = '0;
                    n_state = ssd_pkg::S_SHIFT;
                end else if (r_cnt[r_e] != '0) begin
                    n_cnt[r_e] = r_cnt[r_e] - CW'(1);
                end
            end
            ssd_pkg::S_SHIFT: begin
                // slot k+1 read last cycle lands in slot k
                mem_we = 1'b1;
                mem_waddr = ssd_pkg::base_addr(r_e) + AW'(r_k);
                mem_wdata = mem_rdata;
                if ((r_k + CW'(2)) < r_cnt[r_e]) begin
                    mem_raddr = ssd_pkg::base_addr(r_e) + AW'(r_k) + AW'(2);
                    n_k = r_k + CW'(1);
                end else begin
                    n_cnt[r_e] = r_cnt[r_e] - CW'(1);
                    n_state = ssd_pkg::S_RESP;
                end
            end
            ssd_pkg::S_ST_NEXT: begin
                if (r_i == (IW+1)'(TE)) begin
                    if (r_nfull > (IW+1)'(1)) begin
                        n_i = '0;
                        n_j = '0;
                        n_found = 1'b0;
                        n_grp = '0;
                        n_pvld = 1'b0;
                        n_state = ssd_pkg::S_PAIR;
                    end else begin
                        n_state = ssd_pkg::S_RESP;
                    end
                end else if (full[ii]) begin
                    n_k = '0;
                    n_sum = '0;
                    n_state = ssd_pkg::S_SUM;
                end else begin
                    n_i = r_i + (IW+1)'(1);
                end
            end
            ssd_pkg::S_SUM: begin
                if (r_k < CW'(WD)) begin
                    mem_raddr = ssd_pkg::base_addr(ii) + AW'(r_k);
                    n_k = r_k + CW'(1);
                    n_rv = 1'b1;
                end
                if (r_rv) begin
                    n_sum = r_sum + ssd_pkg::SUM_W'($signed(mem_rdata));
                end
                if (r_k == CW'(WD) && !r_rv) begin
                    stat_req.mean_go = 1'b1;
                    n_state = ssd_pkg::S_MEAN;
                end
            end
            ssd_pkg::S_MEAN: begin
                if (stat_done) begin
                    n_mcur = stat_mean;
                    n_k = '0;
                    n_sq = '0;
                    n_state = ssd_pkg::S_SQ;
                end
            end
            ssd_pkg::S_SQ: begin
                if (r_k < CW'(WD)) begin
                    mem_raddr = ssd_pkg::base_addr(ii) + AW'(r_k);
                    n_k = r_k + CW'(1);
                    n_rv = 1'b1;
                end
                if (r_rv) begin
                    n_sq = r_sq + ssd_pkg::SQ_W'(dsq);
                end
                if (r_k == CW'(WD) && !r_rv) begin
                    stat_req.dev_go = 1'b1;
                    n_state = ssd_pkg::S_DEV;
                end
            end
            ssd_pkg::S_DEV: begin
                if (stat_done) begin
                    n_mean[ii] = r_mcur;
                    n_lo[ii] = stat_lo;
                    n_hi[ii] = stat_hi;
                    n_nfull = r_nfull + (IW+1)'(1);
                    n_i = r_i + (IW+1)'(1);
                    n_state = ssd_pkg::S_ST_NEXT;
                end
            end
            ssd_pkg::S_PAIR: begin
                if (r_i == (IW+1)'(TE)) begin
                    n_state = ssd_pkg::S_FIN;
                end else if (!full[ii]) begin
                    n_i = r_i + (IW+1)'(1);
                    n_j = '0;
                end else begin
                    if (pair_hit) begin
                        n_ovld = r_pvld;
                        n_pvld = 1'b1;
                        n_pid = r_eid[r_j];
                        n_pgrp = r_grp;
                        n_plig = 1'b0;
                        n_found = 1'b1;
                    end
                    if (r_j == IW'(TE - 1)) begin
                        if (r_found || pair_hit) begin
                            n_state = ssd_pkg::S_REF;
                        end else begin
                            n_i = r_i + (IW+1)'(1);
                            n_j = '0;
                        end
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
            end
            ssd_pkg::S_REF: begin
                // reference id closes its group
                n_ovld = r_pvld;
                n_pvld = 1'b1;
                n_pid = r_eid[ii];
                n_pgrp = r_grp;
                n_plig = 1'b1;
                n_grp = r_grp + 3'd1;
                n_found = 1'b0;
                n_i = r_i + (IW+1)'(1);
                n_j = '0;
                n_state = ssd_pkg::S_PAIR;
            end
            ssd_pkg::S_FIN: begin
                if (r_pvld) begin
                    n_ovld = 1'b1;
                    n_out.last = 1'b1;
                    n_pvld = 1'b0;
                    n_suspect = 1'b1;
                    n_state = ssd_pkg::S_IDLE;
                end else begin
                    n_state = ssd_pkg::S_RESP;
                end
            end
            ssd_pkg::S_RESP: begin
                n_ovld = 1'b1;
                n_out.member_valid = 1'b0;
                n_out.member_id = '0;
                n_out.group_index = '0;
                n_out.last_in_group = 1'b0;
                n_out.any_suspect = r_suspect;
                n_out.last = 1'b1;
                n_state = ssd_pkg::S_IDLE;
            end
            default: n_state = ssd_pkg::S_IDLE;
        endcase
    end

    assign busy     = (r_state != ssd_pkg::S_IDLE);
    assign o_strobe = r_ovld;
    assign o_result = r_out;

    `SSD_ASSERT_ALWAYS(a_idle_beat_last, !o_strobe || o_result.member_valid || o_result.last, "empty beat must be last")
    `SSD_ASSERT_NEXT(a_last_gap, o_strobe && o_result.last, !o_strobe, "beat right after last beat")
    `SSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")
endmodule

### hw/rtl/ssd_sample_mem.sv
// ----------------------------------------------------------------------------
// ssd_sample_mem
// Sample window storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssd_sample_mem (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ssd_pkg::ADDR_W-1:0]      i_waddr,
    input  logic [ssd_pkg::SMP_W-1:0]       i_wdata,
    input  logic [ssd_pkg::ADDR_W-1:0]      i_raddr,
    output logic [ssd_pkg::SMP_W-1:0]       o_rdata
);
    logic [ssd_pkg::SMP_W-1:0] r_mem [ssd_pkg::MEM_DEPTH];
    logic [ssd_pkg::SMP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ssd_stat_unit.sv
// ----------------------------------------------------------------------------
// ssd_stat_unit
// Window mean and similarity band: reciprocal divide, bitwise square root.
// ----------------------------------------------------------------------------
module ssd_stat_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ssd_pkg::t_stat_req                     i_req,
    input  logic signed [ssd_pkg::SUM_W-1:0]       i_sum,
    input  logic [ssd_pkg::SQ_W-1:0]               i_sq,
    input  logic signed [ssd_pkg::MEAN_W-1:0]      i_mean,
    input  logic [ssd_pkg::SPREAD_W-1:0]           i_spread,
    output logic                                   o_done,
    output logic signed [ssd_pkg::MEAN_W-1:0]      o_mean,
    output logic signed [ssd_pkg::BAND_W-1:0]      o_lo,
    output logic signed [ssd_pkg::BAND_W-1:0]      o_hi
);
    localparam int BIT_W = $clog2(ssd_pkg::DEV_W);

    ssd_pkg::t_stat_state r_st, n_st;
    logic [ssd_pkg::PROD_W-1:0]       r_prod, n_prod;
    logic                             r_neg, n_neg;
    logic [ssd_pkg::VAR_W-1:0]        r_v, n_v;
    logic [ssd_pkg::DEV_W-1:0]        r_root, n_root;
    logic [BIT_W-1:0]                 r_bit, n_bit;
    logic                             r_done, n_done;
    logic signed [ssd_pkg::MEAN_W-1:0] r_mean, n_mean;
    logic signed [ssd_pkg::BAND_W-1:0] r_lo, n_lo, r_hi, n_hi;

    logic [ssd_pkg::SUM_W-1:0]        mag;
    logic [ssd_pkg::MEAN_W:0]         quo;
    logic [ssd_pkg::DEV_W-1:0]        trial;
    logic [ssd_pkg::VAR_W-1:0]        trial_sq;
    logic [ssd_pkg::BAND_W-1:0]       md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ssd_pkg::SU_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_prod <= n_prod;
        r_neg  <= n_neg;
        r_v    <= n_v;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_mean <= n_mean;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
    end

    always_comb begin
        n_st   = r_st;
        n_prod = r_prod;
        n_neg  = r_neg;
        n_v    = r_v;
        n_root = r_root;
        n_bit  = r_bit;
        n_done = 1'b0;
        n_mean = r_mean;
        n_lo   = r_lo;
        n_hi   = r_hi;
        mag    = i_sum[ssd_pkg::SUM_W-1] ? ssd_pkg::SUM_W'(-i_sum) : ssd_pkg::SUM_W'(i_sum);
        quo    = (ssd_pkg::MEAN_W+1)'(r_prod >> ssd_pkg::SUM_SHIFT);
        trial  = r_root | (ssd_pkg::DEV_W'(1) << r_bit);
        trial_sq = ssd_pkg::VAR_W'(trial) * ssd_pkg::VAR_W'(trial);
        md     = ssd_pkg::BAND_W'(i_spread) * ssd_pkg::BAND_W'(r_root);
        case (r_st)
            ssd_pkg::SU_IDLE: begin
                if (i_req.mean_go) begin
                    n_prod = ssd_pkg::PROD_W'(mag) * ssd_pkg::PROD_W'(ssd_pkg::RECIP_SUM);
                    n_neg  = i_sum[ssd_pkg::SUM_W-1];
                    n_st   = ssd_pkg::SU_MEAN;
                end else if (i_req.dev_go) begin
                    n_prod = ssd_pkg::PROD_W'(i_sq) * ssd_pkg::PROD_W'(ssd_pkg::RECIP_SQ);
                    n_st   = ssd_pkg::SU_DIV;
                end
            end
            ssd_pkg::SU_MEAN: begin
                // truncation toward zero: divide the magnitude, restore sign
                n_mean = r_neg ? ssd_pkg::MEAN_W'(-quo) : ssd_pkg::MEAN_W'(quo);
                n_done = 1'b1;
                n_st   = ssd_pkg::SU_IDLE;
            end
            ssd_pkg::SU_DIV: begin
                n_v    = ssd_pkg::VAR_W'(r_prod >> ssd_pkg::SQ_SHIFT);
                n_root = '0;
                n_bit  = BIT_W'(ssd_pkg::DEV_W - 1);
                n_st   = ssd_pkg::SU_ROOT;
            end
            ssd_pkg::SU_ROOT: begin
                if (trial_sq <= r_v) begin
                    n_root = trial;
                end
                if (r_bit == '0) begin
                    n_st = ssd_pkg::SU_BAND;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            ssd_pkg::SU_BAND: begin
                n_lo   = ssd_pkg::BAND_W'(i_mean) - $signed(md);
                n_hi   = ssd_pkg::BAND_W'(i_mean) + $signed(md);
                n_done = 1'b1;
                n_st   = ssd_pkg::SU_IDLE;
            end
            default: n_st = ssd_pkg::SU_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_mean = r_mean;
    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
endmodule
